FILE: rtl/core/arng_pkg.sv
// Shared types and constants for the address range table with gaps.
// Holds item structs, table entry type, mode and status codes.
// No dependencies.
package arng_pkg;

  localparam int MAX_RANGES   = 16;
  localparam int ADDRESS_BITS = 16;

  localparam int AW  = ADDRESS_BITS;
  localparam int LW  = AW + 1;
  localparam int SW  = AW + 2;
  localparam int CW  = $clog2(MAX_RANGES + 1);
  localparam int IW  = $clog2(MAX_RANGES);
  localparam int PAW = 3;

  localparam logic [LW-1:0] SPACE_TOP = LW'(1) << AW;

  typedef enum logic [1:0] {
    MODE_GAP    = 2'd0,
    MODE_ADDR   = 2'd1,
    MODE_RANGE  = 2'd2,
    MODE_RELOAD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_UNCOVERED = 2'd1,
    STAT_REJECTED  = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    REG_BASE = 1'b0,
    REG_SIZE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    mode_t         mode;
    logic [AW-1:0] address;
    logic [LW-1:0] length;
  } in_item_t;

  typedef struct packed {
    status_t       status;
    logic          hit;
    logic [CW-1:0] range_count;
  } out_item_t;

  typedef struct packed {
    logic [AW-1:0] base;
    logic [LW-1:0] limit;
  } entry_t;

endpackage

FILE: rtl/core/arng_table.sv
// Range table storage: one write port, one read port with registered data.
// Depends on arng_pkg for the entry type and table depth.
module arng_table import arng_pkg::*; (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [MAX_RANGES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/address_range_table_with_gaps.sv
// Top level of the address range table with gaps: sequencer, shared compare
// path, configuration registers. Depends on arng_pkg and arng_table.
//
// Usage:
//   Input channel: an item (mode, address, length) is taken at a rising edge
//   with start high and busy low. busy stays high while the item is worked.
//   Result channel: out_valid is high for exactly one cycle with out_data;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   Configuration: APB-style port, base_address at 0x0, space_size at 0x4;
//   pready is always high. Write only while busy is low and no result is
//   pending; a new size or base applies at the next reload item.
// Sequencing: zero-length and empty-table items are answered from idle, and a
//   reload writes the table in its own state. Lookups and gaps scan
//   one entry per cycle through the single compare path, stopping at the
//   first hit or after the last entry. A gap adds a decide state, and a
//   split or removal moves one entry per cycle through the single table
//   write port. The next item can be accepted at the edge that takes the
//   result.
// Reset: synchronous, active low. The table holds the single range
//   [0, 65536) and the registers take their reset values.
module address_range_table_with_gaps import arng_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_data,
  output logic            out_valid,
  output out_item_t       out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [PAW-1:0]  paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT_UP,
    ST_SPLIT_HI,
    ST_SHIFT_DOWN
  } state_t;

  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [SW-1:0] ge_r, ge_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] k_r, k_nxt;
  entry_t        ent_r, ent_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic [AW-1:0] base_r;
  logic [LW-1:0] size_r;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;
  entry_t        rdata;

  logic [SW-1:0] in_ge;
  logic [SW-1:0] init_sum;
  logic [LW-1:0] init_limit;
  logic [CW-1:0] cnt_m1;
  logic          hit_now;
  logic          has_lo;
  logic          has_hi;
  logic          is_last;
  logic          cfg_wr;
  reg_idx_t      cfg_idx;

  arng_table u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= SPACE_TOP;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BASE: base_r <= pwdata[AW-1:0];
        REG_SIZE: size_r <= pwdata[LW-1:0];
        default:  base_r <= base_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BASE: prdata = 32'(base_r);
      REG_SIZE: prdata = 32'(size_r);
      default:  prdata = '0;
    endcase
  end

  assign in_ge = SW'(in_data.address) +
                 ((in_data.mode == MODE_ADDR) ? SW'(1) : SW'(in_data.length));

  assign init_sum   = SW'(base_r) + SW'(size_r);
  assign init_limit = (init_sum > SW'(SPACE_TOP)) ? SPACE_TOP : init_sum[LW-1:0];

  assign cnt_m1  = count_r - CW'(1);
  assign hit_now = (rdata.base <= a_r) && (ge_r <= SW'(rdata.limit));
  assign has_lo  = (a_r > ent_r.base);
  assign has_hi  = (ge_r < SW'(ent_r.limit));
  assign is_last = ((CW'(idx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    a_nxt         = a_r;
    ge_nxt        = ge_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    ent_nxt       = ent_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    out_nxt.status = STAT_DONE;
    out_nxt.hit    = 1'b0;
    we            = 1'b0;
    waddr         = k_r;
    wdata         = ent_r;
    raddr         = '0;

    unique case (state_r)
      ST_IDLE: begin
        raddr = '0;
        if (start) begin
          mode_nxt = in_data.mode;
          a_nxt    = in_data.address;
          ge_nxt   = in_ge;
          idx_nxt  = '0;
          case (in_data.mode)
            MODE_RELOAD: begin
              state_nxt = ST_RELOAD;
            end
            MODE_GAP: begin
              if (in_data.length == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STAT_REJECTED;
              end else if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STAT_UNCOVERED;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              if (((in_data.mode == MODE_RANGE) && (in_data.length == '0)) ||
                  (count_r == '0)) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_RELOAD: begin
        we          = 1'b1;
        waddr       = '0;
        wdata.base  = base_r;
        wdata.limit = init_limit;
        count_nxt   = (size_r != '0) ? CW'(1) : '0;
        out_valid_nxt = 1'b1;
        state_nxt   = ST_IDLE;
      end

      ST_SCAN: begin
        raddr = idx_r + IW'(1);
        if (hit_now) begin
          k_nxt   = idx_r;
          ent_nxt = rdata;
          if (mode_r == MODE_GAP) begin
            state_nxt = ST_DECIDE;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt.hit   = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (is_last) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = (mode_r == MODE_GAP) ? STAT_UNCOVERED : STAT_DONE;
          state_nxt      = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      ST_DECIDE: begin
        raddr = (has_lo && has_hi) ? cnt_m1[IW-1:0] : (k_r + IW'(1));
        if (!has_lo && !has_hi) begin
          if (CW'(k_r) == cnt_m1) begin
            count_nxt     = cnt_m1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            idx_nxt   = k_r;
            state_nxt = ST_SHIFT_DOWN;
          end
        end else if (has_lo && has_hi && (count_r == CW'(MAX_RANGES))) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = STAT_FULL;
          state_nxt      = ST_IDLE;
        end else begin
          we    = 1'b1;
          waddr = k_r;
          if (has_lo) begin
            wdata.base  = ent_r.base;
            wdata.limit = LW'(a_r);
          end else begin
            wdata.base  = ge_r[AW-1:0];
            wdata.limit = ent_r.limit;
          end
          if (!(has_lo && has_hi)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else if (CW'(k_r) == cnt_m1) begin
            state_nxt = ST_SPLIT_HI;
          end else begin
            idx_nxt   = count_r[IW-1:0];
            state_nxt = ST_SHIFT_UP;
          end
        end
      end

      ST_SHIFT_UP: begin
        raddr = idx_r - IW'(2);
        we    = 1'b1;
        waddr = idx_r;
        wdata = rdata;
        if (CW'(idx_r) == (CW'(k_r) + CW'(2))) begin
          state_nxt = ST_SPLIT_HI;
        end else begin
          idx_nxt = idx_r - IW'(1);
        end
      end

      ST_SPLIT_HI: begin
        we          = 1'b1;
        waddr       = k_r + IW'(1);
        wdata.base  = ge_r[AW-1:0];
        wdata.limit = ent_r.limit;
        count_nxt   = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        state_nxt   = ST_IDLE;
      end

      ST_SHIFT_DOWN: begin
        raddr = idx_r + IW'(2);
        we    = 1'b1;
        waddr = idx_r;
        wdata = rdata;
        if ((CW'(idx_r) + CW'(2)) == count_r) begin
          count_nxt     = cnt_m1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_nxt.range_count = count_nxt;

    if (!rst_n) begin
      we          = 1'b1;
      waddr       = '0;
      wdata.base  = '0;
      wdata.limit = SPACE_TOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r <= mode_nxt;
    a_r    <= a_nxt;
    ge_r   <= ge_nxt;
    idx_r  <= idx_nxt;
    k_r    <= k_nxt;
    ent_r  <= ent_nxt;
    out_r  <= out_nxt;
  end

endmodule
